// ----- rtl/drt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types and constants of the display row transfer sequencer.
// ----------------------------------------------------------------------------
package drt_pkg;

	localparam int MAX_DIM    = 1024;
	localparam int TIMER_BITS = 20;
	localparam int DIM_W      = 11;
	localparam int ROW_W      = 10;
	localparam int OFS_W      = 8;
	localparam int BYTES_W    = 22;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// job queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QLVL_W = $clog2(QDEPTH + 1);

	// request codes
	localparam logic [1:0] REQ_BEGIN  = 2'd0;
	localparam logic [1:0] REQ_POLL   = 2'd1;
	localparam logic [1:0] REQ_CANCEL = 2'd2;
	localparam logic [1:0] REQ_TICK   = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_CMD    = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_DMA    = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	// status codes
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_ACTIVE   = 3'd1;
	localparam logic [2:0] ST_COMPLETE = 3'd2;
	localparam logic [2:0] ST_ERROR    = 3'd3;
	localparam logic [2:0] ST_ACCEPTED = 3'd4;
	localparam logic [2:0] ST_REJECTED = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DMA_TIMEOUT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIFO_TIMEOUT = 3'd4;

	// register reset values
	localparam logic [OFS_W-1:0]      RST_COLUMN_OFS   = 8'd16;
	localparam logic [TIMER_BITS-1:0] RST_DMA_TIMEOUT  = 20'd250000;
	localparam logic [TIMER_BITS-1:0] RST_FIFO_TIMEOUT = 20'd20000;

	// panel commands
	localparam logic [7:0] CMD_CASET = 8'h2a;
	localparam logic [7:0] CMD_RASET = 8'h2b;
	localparam logic [7:0] CMD_RAMWR = 8'h2c;

	// one classified request, ready for the back end
	typedef struct packed {
		logic               is_begin;
		logic [2:0]         status;
		logic               recover;
		logic               frame_end;
		logic [OFS_W-1:0]   x0;
		logic [DIM_W-1:0]   x1;
		logic [ROW_W-1:0]   y0;
		logic [ROW_W-1:0]   y1;
		logic [BYTES_W-1:0] byte_offset;
		logic [BYTES_W-1:0] dma_len;
	} job_t;

endpackage
`default_nettype wire

// ----- rtl/drt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drt_if
// Valid/ready channels of the sequencer: requests, results, register writes.
// ----------------------------------------------------------------------------
interface drt_req_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               req_type;
	logic [drt_pkg::ROW_W-1:0] row_start;
	logic [drt_pkg::DIM_W-1:0] row_end;
	logic                     image_valid;
	logic                     dma_busy;
	logic                     fifo_empty;

	modport source (output valid, req_type, row_start, row_end, image_valid,
		dma_busy, fifo_empty, input ready);
	modport sink (input valid, req_type, row_start, row_end, image_valid,
		dma_busy, fifo_empty, output ready);
endinterface

interface drt_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  out_kind;
	logic [7:0]                  byte_value;
	logic                        frame_end;
	logic [drt_pkg::BYTES_W-1:0] dma_byte_offset;
	logic [drt_pkg::BYTES_W-1:0] dma_byte_count;
	logic [2:0]                  status;
	logic                        recover;
	logic                        last;

	modport source (output valid, out_kind, byte_value, frame_end, dma_byte_offset,
		dma_byte_count, status, recover, last, input ready);
	modport sink (input valid, out_kind, byte_value, frame_end, dma_byte_offset,
		dma_byte_count, status, recover, last, output ready);
endinterface

interface drt_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [drt_pkg::CFG_IDX_W-1:0]  index;
	logic [drt_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/display_row_transfer_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// display_row_transfer_sequencer
// Starts and supervises panel row transfers: window setup bytes, DMA start,
// DMA wait and FIFO drain phases with microsecond timeouts and recovery.
// ----------------------------------------------------------------------------
// The first result of a request passes through the job queue, then the output
// register. A request is taken every cycle while the job queue has room; the
// back end sends one result per cycle while the receiver is ready; an accepted
// begin yields 13 results, every other request one, and ticks none.
// Reset: registers return to their defaults, phase idle, timer zero, queue
// and output register empty.
module display_row_transfer_sequencer (
	input  wire logic clk,
	input  wire logic arst_n,
	drt_req_if.sink   req,
	drt_rsp_if.source rsp,
	drt_cfg_if.sink   cfg
);

	logic                         push;
	drt_pkg::job_t                push_job;
	logic                         pop;
	logic                         head_valid;
	drt_pkg::job_t                head_job;
	logic [drt_pkg::QLVL_W-1:0]   level;
	logic                         space;

	assign space = level != drt_pkg::QLVL_W'(drt_pkg::QDEPTH);

	drt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg),
		.space  (space),
		.push   (push),
		.job    (push_job)
	);

	drt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job),
		.level      (level)
	);

	drt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.rsp        (rsp)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= drt_pkg::QLVL_W'(drt_pkg::QDEPTH))
		else $error("job queue over capacity");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!space |-> !push)
		else $error("job pushed into full queue");

	a_dma_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.out_kind == drt_pkg::KIND_DMA
		|-> rsp.last && rsp.status == drt_pkg::ST_ACCEPTED)
		else $error("DMA start not final accepted result");

	a_cmd_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ready && rsp.out_kind == drt_pkg::KIND_CMD
		|=> rsp.valid)
		else $error("command byte not followed by more results");

endmodule
`default_nettype wire

// ----- rtl/drt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drt_front
// Register file, transfer phase and timer; classifies each request into a job.
// ----------------------------------------------------------------------------
module drt_front (
	input  wire logic       clk,
	input  wire logic       arst_n,
	drt_req_if.sink         req,
	drt_cfg_if.sink         cfg,
	input  wire logic       space,
	output logic            push,
	output drt_pkg::job_t   job
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DMA  = 2'd1,
		PH_FIFO = 2'd2
	} phase_t;

	localparam logic [drt_pkg::DIM_W-1:0] MAX_DIM_V = drt_pkg::DIM_W'(drt_pkg::MAX_DIM);

	phase_t                          phase_q, phase_d;
	logic [drt_pkg::TIMER_BITS-1:0]  elapsed_q, elapsed_d;
	logic [drt_pkg::DIM_W-1:0]       width_q, height_q;
	logic [drt_pkg::OFS_W-1:0]       col_ofs_q;
	logic [drt_pkg::TIMER_BITS-1:0]  dma_to_q, fifo_to_q;

	logic                            accept;
	logic                            active;
	logic                            reject;
	logic                            do_fifo;
	logic [drt_pkg::TIMER_BITS-1:0]  fifo_el;
	logic [drt_pkg::DIM_W-1:0]       rows;
	logic [drt_pkg::DIM_W+drt_pkg::ROW_W-1:0] prod_ofs, prod_cnt;
	logic [drt_pkg::DIM_W-1:0]       cfg_dim;

	assign req.ready = space;
	assign cfg.ready = 1'b1;
	assign accept    = req.valid && space;
	assign active    = phase_q != PH_IDLE;
	assign push      = accept && (req.req_type != drt_pkg::REQ_TICK);

	assign rows     = req.row_end - {1'b0, req.row_start};
	assign prod_ofs = {{drt_pkg::DIM_W{1'b0}}, req.row_start} *
		{{drt_pkg::ROW_W{1'b0}}, width_q};
	assign prod_cnt = {{drt_pkg::ROW_W{1'b0}}, rows} *
		{{drt_pkg::ROW_W{1'b0}}, width_q};

	assign reject = active || req.dma_busy || !req.image_valid ||
		({1'b0, req.row_start} >= req.row_end) || (req.row_end > height_q) ||
		(width_q == '0);

	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		job       = '0;
		do_fifo   = 1'b0;
		fifo_el   = elapsed_q;

		job.x0          = col_ofs_q;
		job.x1          = width_q + {{(drt_pkg::DIM_W-drt_pkg::OFS_W){1'b0}}, col_ofs_q}
			- drt_pkg::DIM_W'(1);
		job.y0          = req.row_start;
		job.y1          = drt_pkg::ROW_W'(req.row_end - drt_pkg::DIM_W'(1));
		job.byte_offset = {prod_ofs, 1'b0};
		job.dma_len     = {prod_cnt, 1'b0};

		unique case (req.req_type)
			drt_pkg::REQ_BEGIN: begin
				if (reject) begin
					job.status = drt_pkg::ST_REJECTED;
				end else begin
					job.is_begin = 1'b1;
					job.status   = drt_pkg::ST_ACCEPTED;
					phase_d      = PH_DMA;
					elapsed_d    = '0;
				end
			end
			drt_pkg::REQ_POLL: begin
				unique case (phase_q)
					PH_IDLE: job.status = drt_pkg::ST_IDLE;
					PH_DMA: begin
						if (req.dma_busy) begin
							if (elapsed_q >= dma_to_q) begin
								job.status  = drt_pkg::ST_ERROR;
								job.recover = 1'b1;
								phase_d     = PH_IDLE;
								elapsed_d   = '0;
							end else begin
								job.status = drt_pkg::ST_ACTIVE;
							end
						end else begin
							do_fifo = 1'b1;
							fifo_el = '0;
						end
					end
					PH_FIFO: do_fifo = 1'b1;
					default: begin
						job.status  = drt_pkg::ST_ERROR;
						job.recover = 1'b1;
						phase_d     = PH_IDLE;
						elapsed_d   = '0;
					end
				endcase
				// drain check, also reached straight from DMA wait
				if (do_fifo) begin
					if (req.fifo_empty) begin
						job.status    = drt_pkg::ST_COMPLETE;
						job.frame_end = 1'b1;
						phase_d       = PH_IDLE;
						elapsed_d     = '0;
					end else if (fifo_el >= fifo_to_q) begin
						job.status  = drt_pkg::ST_ERROR;
						job.recover = 1'b1;
						phase_d     = PH_IDLE;
						elapsed_d   = '0;
					end else begin
						job.status = drt_pkg::ST_ACTIVE;
						phase_d    = PH_FIFO;
						elapsed_d  = fifo_el;
					end
				end
			end
			drt_pkg::REQ_CANCEL: begin
				job.status = drt_pkg::ST_IDLE;
				if (active || req.dma_busy) begin
					job.recover = 1'b1;
					phase_d     = PH_IDLE;
					elapsed_d   = '0;
				end
			end
			drt_pkg::REQ_TICK: begin
				if (active && (elapsed_q != '1))
					elapsed_d = elapsed_q + drt_pkg::TIMER_BITS'(1);
			end
			default: ;
		endcase
	end

	assign cfg_dim = (cfg.data[drt_pkg::DIM_W-1:0] > MAX_DIM_V) ? MAX_DIM_V :
		cfg.data[drt_pkg::DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
			width_q   <= '0;
			height_q  <= '0;
			col_ofs_q <= drt_pkg::RST_COLUMN_OFS;
			dma_to_q  <= drt_pkg::RST_DMA_TIMEOUT;
			fifo_to_q <= drt_pkg::RST_FIFO_TIMEOUT;
		end else begin
			if (accept) begin
				phase_q   <= phase_d;
				elapsed_q <= elapsed_d;
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					drt_pkg::REG_PANEL_WIDTH:  width_q   <= cfg_dim;
					drt_pkg::REG_PANEL_HEIGHT: height_q  <= cfg_dim;
					drt_pkg::REG_COLUMN_OFS:   col_ofs_q <= cfg.data[drt_pkg::OFS_W-1:0];
					drt_pkg::REG_DMA_TIMEOUT:  dma_to_q  <= cfg.data[drt_pkg::TIMER_BITS-1:0];
					drt_pkg::REG_FIFO_TIMEOUT: fifo_to_q <= cfg.data[drt_pkg::TIMER_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/drt_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drt_queue
// Short job queue that decouples request classification from result emission.
// ----------------------------------------------------------------------------
module drt_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire drt_pkg::job_t               push_job,
	input  wire logic                        pop,
	output logic                             head_valid,
	output drt_pkg::job_t                    head_job,
	output logic [drt_pkg::QLVL_W-1:0]       level
);

	localparam logic [drt_pkg::QPTR_W-1:0] PTR_LAST = drt_pkg::QPTR_W'(drt_pkg::QDEPTH - 1);

	drt_pkg::job_t                    mem_q [drt_pkg::QDEPTH];
	logic [drt_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [drt_pkg::QLVL_W-1:0]       level_q;
	logic                             do_pop;

	assign head_valid = level_q != '0;
	assign head_job   = mem_q[rd_ptr_q];
	assign level      = level_q;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + drt_pkg::QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + drt_pkg::QPTR_W'(1);
			if (push && !do_pop)
				level_q <= level_q + drt_pkg::QLVL_W'(1);
			else if (!push && do_pop)
				level_q <= level_q - drt_pkg::QLVL_W'(1);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/drt_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drt_back
// Sequences job results into output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module drt_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire drt_pkg::job_t head_job,
	output logic               pop,
	drt_rsp_if.source          rsp
);

	localparam int            STEP_W    = 4;
	localparam logic [STEP_W-1:0] STEP_LAST = 4'd12;

	typedef struct packed {
		logic [1:0]                  kind;
		logic [7:0]                  byte_value;
		logic                        frame_end;
		logic [drt_pkg::BYTES_W-1:0] byte_offset;
		logic [drt_pkg::BYTES_W-1:0] dma_len;
		logic [2:0]                  status;
		logic                        recover;
		logic                        last;
	} rsp_t;

	logic [STEP_W-1:0] step_q;
	logic              ov_q;
	rsp_t              out_q;
	rsp_t              nxt;
	logic              advance;
	logic              job_done;

	function automatic logic [7:0] data_byte(input logic [15:0] v, input logic hi);
		return hi ? v[15:8] : v[7:0];
	endfunction

	always_comb begin
		logic [15:0] x0w, x1w, y0w, y1w;
		x0w = 16'(head_job.x0);
		x1w = 16'(head_job.x1);
		y0w = 16'(head_job.y0);
		y1w = 16'(head_job.y1);
		nxt = '0;
		nxt.status  = head_job.status;
		nxt.recover = head_job.recover;
		if (!head_job.is_begin) begin
			nxt.kind      = drt_pkg::KIND_STATUS;
			nxt.frame_end = head_job.frame_end;
			nxt.last      = 1'b1;
		end else begin
			nxt.kind = drt_pkg::KIND_DATA;
			unique case (step_q)
				4'd0: begin
					nxt.kind       = drt_pkg::KIND_CMD;
					nxt.byte_value = drt_pkg::CMD_CASET;
				end
				4'd1: nxt.byte_value = data_byte(x0w, 1'b1);
				4'd2: nxt.byte_value = data_byte(x0w, 1'b0);
				4'd3: nxt.byte_value = data_byte(x1w, 1'b1);
				4'd4: begin
					nxt.byte_value = data_byte(x1w, 1'b0);
					nxt.frame_end  = 1'b1;
				end
				4'd5: begin
					nxt.kind       = drt_pkg::KIND_CMD;
					nxt.byte_value = drt_pkg::CMD_RASET;
				end
				4'd6: nxt.byte_value = data_byte(y0w, 1'b1);
				4'd7: nxt.byte_value = data_byte(y0w, 1'b0);
				4'd8: nxt.byte_value = data_byte(y1w, 1'b1);
				4'd9: begin
					nxt.byte_value = data_byte(y1w, 1'b0);
					nxt.frame_end  = 1'b1;
				end
				4'd10: begin
					nxt.kind       = drt_pkg::KIND_CMD;
					nxt.byte_value = drt_pkg::CMD_RAMWR;
					nxt.frame_end  = 1'b1;
				end
				// second write-memory command keeps select asserted for the DMA
				4'd11: begin
					nxt.kind       = drt_pkg::KIND_CMD;
					nxt.byte_value = drt_pkg::CMD_RAMWR;
				end
				default: begin
					nxt.kind        = drt_pkg::KIND_DMA;
					nxt.byte_offset = head_job.byte_offset;
					nxt.dma_len     = head_job.dma_len;
					nxt.last        = 1'b1;
				end
			endcase
		end
	end

	assign advance  = !ov_q || rsp.ready;
	assign job_done = !head_job.is_begin || (step_q >= STEP_LAST);
	assign pop      = advance && head_valid && job_done;

	always_ff @(posedge clk) begin
		if (advance && head_valid)
			out_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			step_q <= '0;
		end else if (advance) begin
			ov_q <= head_valid;
			if (head_valid)
				step_q <= job_done ? '0 : step_q + STEP_W'(1);
		end
	end

	assign rsp.valid           = ov_q;
	assign rsp.out_kind        = out_q.kind;
	assign rsp.byte_value      = out_q.byte_value;
	assign rsp.frame_end       = out_q.frame_end;
	assign rsp.dma_byte_offset = out_q.byte_offset;
	assign rsp.dma_byte_count  = out_q.dma_len;
	assign rsp.status          = out_q.status;
	assign rsp.recover         = out_q.recover;
	assign rsp.last            = out_q.last;

endmodule
`default_nettype wire

// ----- verif/display_row_transfer_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_row_transfer_sequencer_tb
// Self-checking bench for the row transfer sequencer. Requests go in on a
// valid/ready channel with random gaps, results leave through a randomly
// stalled channel, and a scoreboard with its own copy of the phase and timer
// state predicts every result, which is compared field by field in order.
// ----------------------------------------------------------------------------
module display_row_transfer_sequencer_tb;

	localparam logic [drt_pkg::DIM_W-1:0] DIM_CAP = drt_pkg::DIM_W'(drt_pkg::MAX_DIM);

	typedef struct {
		logic [1:0]                req_type;
		logic [drt_pkg::ROW_W-1:0] row_start;
		logic [drt_pkg::DIM_W-1:0] row_end;
		logic                      image_valid;
		logic                      dma_busy;
		logic                      fifo_empty;
	} request_t;

	typedef struct {
		logic [1:0]                  out_kind;
		logic [7:0]                  byte_value;
		logic                        frame_end;
		logic [drt_pkg::BYTES_W-1:0] dma_byte_offset;
		logic [drt_pkg::BYTES_W-1:0] dma_byte_count;
		logic [2:0]                  status;
		logic                        recover;
		logic                        last;
	} result_t;

	typedef enum logic [1:0] {PH_IDLE, PH_DMA_WAIT, PH_FIFO_DRAIN} phase_t;

	class transfer_scoreboard;
		logic [drt_pkg::DIM_W-1:0]      panel_w;
		logic [drt_pkg::DIM_W-1:0]      panel_h;
		logic [drt_pkg::OFS_W-1:0]      col_ofs;
		logic [drt_pkg::TIMER_BITS-1:0] dma_limit;
		logic [drt_pkg::TIMER_BITS-1:0] fifo_limit;
		phase_t                         phase;
		logic [drt_pkg::TIMER_BITS-1:0] elapsed;
		result_t                        queued_results[$];
		int                             fail_count;

		function new();
			panel_w    = '0;
			panel_h    = '0;
			col_ofs    = drt_pkg::RST_COLUMN_OFS;
			dma_limit  = drt_pkg::RST_DMA_TIMEOUT;
			fifo_limit = drt_pkg::RST_FIFO_TIMEOUT;
			phase      = PH_IDLE;
			elapsed    = '0;
			fail_count = 0;
		endfunction

		function int outstanding();
			return queued_results.size();
		endfunction

		function void write_reg(logic [drt_pkg::CFG_IDX_W-1:0] idx,
				logic [drt_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				drt_pkg::REG_PANEL_WIDTH:  panel_w = (d[10:0] > DIM_CAP) ? DIM_CAP : d[10:0];
				drt_pkg::REG_PANEL_HEIGHT: panel_h = (d[10:0] > DIM_CAP) ? DIM_CAP : d[10:0];
				drt_pkg::REG_COLUMN_OFS:   col_ofs = d[7:0];
				drt_pkg::REG_DMA_TIMEOUT:  dma_limit = d[19:0];
				drt_pkg::REG_FIFO_TIMEOUT: fifo_limit = d[19:0];
				default: ;
			endcase
		endfunction

		function void push(logic [1:0] kind, logic [7:0] b, logic fend,
				logic [drt_pkg::BYTES_W-1:0] off, logic [drt_pkg::BYTES_W-1:0] cnt,
				logic [2:0] st, logic rec, logic lst);
			result_t e;
			e.out_kind = kind;
			e.byte_value = b;
			e.frame_end = fend;
			e.dma_byte_offset = off;
			e.dma_byte_count = cnt;
			e.status = st;
			e.recover = rec;
			e.last = lst;
			queued_results.push_back(e);
		endfunction

		function void note_request(request_t r);
			logic [15:0] x1;
			logic [15:0] y1;
			logic [31:0] off;
			logic [31:0] cnt;
			logic [2:0]  st;
			logic        rec;
			logic        fend;
			st = drt_pkg::ST_IDLE;
			rec = 1'b0;
			fend = 1'b0;
			case (r.req_type)
				drt_pkg::REQ_BEGIN: begin
					if (phase != PH_IDLE || r.dma_busy || !r.image_valid ||
							{1'b0, r.row_start} >= r.row_end || r.row_end > panel_h ||
							panel_w == '0) begin
						push(drt_pkg::KIND_STATUS, 8'h00, 1'b0, '0, '0, drt_pkg::ST_REJECTED,
							1'b0, 1'b1);
						return;
					end
					x1 = 16'(panel_w) + 16'(col_ofs) - 16'd1;
					y1 = 16'(r.row_end) - 16'd1;
					off = 32'(r.row_start) * 32'(panel_w) * 2;
					cnt = (32'(r.row_end) - 32'(r.row_start)) * 32'(panel_w) * 2;
					push(drt_pkg::KIND_CMD, drt_pkg::CMD_CASET, 1'b0, '0, '0,
						drt_pkg::ST_ACCEPTED, 1'b0, 1'b0);
					push(drt_pkg::KIND_DATA, 8'h00, 1'b0, '0, '0, drt_pkg::ST_ACCEPTED,
						1'b0, 1'b0);
					push(drt_pkg::KIND_DATA, col_ofs, 1'b0, '0, '0, drt_pkg::ST_ACCEPTED,
						1'b0, 1'b0);
					push(drt_pkg::KIND_DATA, x1[15:8], 1'b0, '0, '0, drt_pkg::ST_ACCEPTED,
						1'b0, 1'b0);
					push(drt_pkg::KIND_DATA, x1[7:0], 1'b1, '0, '0, drt_pkg::ST_ACCEPTED,
						1'b0, 1'b0);
					push(drt_pkg::KIND_CMD, drt_pkg::CMD_RASET, 1'b0, '0, '0,
						drt_pkg::ST_ACCEPTED, 1'b0, 1'b0);
					push(drt_pkg::KIND_DATA, {6'd0, r.row_start[9:8]}, 1'b0, '0, '0,
						drt_pkg::ST_ACCEPTED, 1'b0, 1'b0);
					push(drt_pkg::KIND_DATA, r.row_start[7:0], 1'b0, '0, '0,
						drt_pkg::ST_ACCEPTED, 1'b0, 1'b0);
					push(drt_pkg::KIND_DATA, y1[15:8], 1'b0, '0, '0, drt_pkg::ST_ACCEPTED,
						1'b0, 1'b0);
					push(drt_pkg::KIND_DATA, y1[7:0], 1'b1, '0, '0, drt_pkg::ST_ACCEPTED,
						1'b0, 1'b0);
					push(drt_pkg::KIND_CMD, drt_pkg::CMD_RAMWR, 1'b1, '0, '0,
						drt_pkg::ST_ACCEPTED, 1'b0, 1'b0);
					// second write-memory keeps select asserted for the DMA burst
					push(drt_pkg::KIND_CMD, drt_pkg::CMD_RAMWR, 1'b0, '0, '0,
						drt_pkg::ST_ACCEPTED, 1'b0, 1'b0);
					push(drt_pkg::KIND_DMA, 8'h00, 1'b0, off[21:0], cnt[21:0],
						drt_pkg::ST_ACCEPTED, 1'b0, 1'b1);
					phase = PH_DMA_WAIT;
					elapsed = '0;
					return;
				end
				drt_pkg::REQ_POLL: begin
					if (phase == PH_DMA_WAIT) begin
						if (r.dma_busy) begin
							if (elapsed >= dma_limit) begin
								phase = PH_IDLE;
								elapsed = '0;
								st = drt_pkg::ST_ERROR;
								rec = 1'b1;
							end else begin
								st = drt_pkg::ST_ACTIVE;
							end
							push(drt_pkg::KIND_STATUS, 8'h00, 1'b0, '0, '0, st, rec, 1'b1);
							return;
						end
						// DMA done: drain check follows in the same poll
						phase = PH_FIFO_DRAIN;
						elapsed = '0;
					end
					if (phase == PH_FIFO_DRAIN) begin
						if (!r.fifo_empty) begin
							if (elapsed >= fifo_limit) begin
								phase = PH_IDLE;
								elapsed = '0;
								st = drt_pkg::ST_ERROR;
								rec = 1'b1;
							end else begin
								st = drt_pkg::ST_ACTIVE;
							end
						end else begin
							phase = PH_IDLE;
							elapsed = '0;
							st = drt_pkg::ST_COMPLETE;
							fend = 1'b1;
						end
					end
				end
				drt_pkg::REQ_CANCEL: begin
					if (phase != PH_IDLE || r.dma_busy) begin
						phase = PH_IDLE;
						elapsed = '0;
						rec = 1'b1;
					end
				end
				default: begin
					if (phase != PH_IDLE && elapsed != '1)
						elapsed = elapsed + drt_pkg::TIMER_BITS'(1);
					return;
				end
			endcase
			push(drt_pkg::KIND_STATUS, 8'h00, fend, '0, '0, st, rec, 1'b1);
		endfunction

		function void report(string name, logic [drt_pkg::BYTES_W-1:0] e,
				logic [drt_pkg::BYTES_W-1:0] a);
			fail_count++;
			$display("%0t: %s expected %0h, got %0h", $time, name, e, a);
		endfunction

		function void check_result(result_t a);
			result_t e;
			if (queued_results.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing expected: kind %0h status %0h",
					$time, a.out_kind, a.status);
				return;
			end
			e = queued_results.pop_front();
			if (a.out_kind !== e.out_kind)
				report("out_kind", drt_pkg::BYTES_W'(e.out_kind),
					drt_pkg::BYTES_W'(a.out_kind));
			if (a.byte_value !== e.byte_value)
				report("byte_value", drt_pkg::BYTES_W'(e.byte_value),
					drt_pkg::BYTES_W'(a.byte_value));
			if (a.frame_end !== e.frame_end)
				report("frame_end", drt_pkg::BYTES_W'(e.frame_end),
					drt_pkg::BYTES_W'(a.frame_end));
			if (a.dma_byte_offset !== e.dma_byte_offset)
				report("dma_byte_offset", e.dma_byte_offset, a.dma_byte_offset);
			if (a.dma_byte_count !== e.dma_byte_count)
				report("dma_byte_count", e.dma_byte_count, a.dma_byte_count);
			if (a.status !== e.status)
				report("status", drt_pkg::BYTES_W'(e.status), drt_pkg::BYTES_W'(a.status));
			if (a.recover !== e.recover)
				report("recover", drt_pkg::BYTES_W'(e.recover),
					drt_pkg::BYTES_W'(a.recover));
			if (a.last !== e.last)
				report("last", drt_pkg::BYTES_W'(e.last), drt_pkg::BYTES_W'(a.last));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	drt_req_if req_bus();
	drt_rsp_if rsp_bus();
	drt_cfg_if cfg_bus();

	display_row_transfer_sequencer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	transfer_scoreboard sb = new();

	int snd_idle = 34;
	int rcv_idle = 61;
	int n_sent = 0;
	int hold_asks = 0;
	int hold_done = 0;
	int hold_left = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver: random stalls, plus a long hold-off whenever the driver asks
	always @(negedge clk) begin
		if (hold_asks != hold_done) begin
			hold_done = hold_asks;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		result_t a;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			a.out_kind = rsp_bus.out_kind;
			a.byte_value = rsp_bus.byte_value;
			a.frame_end = rsp_bus.frame_end;
			a.dma_byte_offset = rsp_bus.dma_byte_offset;
			a.dma_byte_count = rsp_bus.dma_byte_count;
			a.status = rsp_bus.status;
			a.recover = rsp_bus.recover;
			a.last = rsp_bus.last;
			sb.check_result(a);
		end
	end

	function automatic request_t mk_req(logic [1:0] t, int rs, int re, int img, int busy,
			int fe);
		request_t r;
		r.req_type = t;
		r.row_start = drt_pkg::ROW_W'(rs);
		r.row_end = drt_pkg::DIM_W'(re);
		r.image_valid = (img != 0);
		r.dma_busy = (busy != 0);
		r.fifo_empty = (fe != 0);
		return r;
	endfunction

	function automatic request_t random_req(logic [1:0] t);
		int re;
		re = ($urandom_range(1) != 0) ? $urandom_range(2047)
			: $urandom_range(drt_pkg::MAX_DIM);
		return mk_req(t, $urandom_range(1023), re, $urandom_range(1), $urandom_range(1),
			$urandom_range(1));
	endfunction

	task automatic send_req(input request_t r);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.req_type <= r.req_type;
		req_bus.row_start <= r.row_start;
		req_bus.row_end <= r.row_end;
		req_bus.image_valid <= r.image_valid;
		req_bus.dma_busy <= r.dma_busy;
		req_bus.fifo_empty <= r.fifo_empty;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		sb.note_request(r);
		n_sent++;
	endtask

	// stop offering and wait until every predicted result has been taken
	task automatic drain();
		@(negedge clk);
		req_bus.valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(logic [drt_pkg::CFG_IDX_W-1:0] idx,
			logic [drt_pkg::CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= d;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		sb.write_reg(idx, d);
	endtask

	// ticks leave no result, so give the queue time to empty before writing
	task automatic load_panel(int w, int h, int ofs, int dto, int fto);
		drain();
		repeat (8) @(posedge clk);
		cfg_write(drt_pkg::REG_PANEL_WIDTH, drt_pkg::CFG_DATA_W'(w));
		cfg_write(drt_pkg::REG_PANEL_HEIGHT, drt_pkg::CFG_DATA_W'(h));
		cfg_write(drt_pkg::REG_COLUMN_OFS, drt_pkg::CFG_DATA_W'(ofs));
		cfg_write(drt_pkg::REG_DMA_TIMEOUT, drt_pkg::CFG_DATA_W'(dto));
		cfg_write(drt_pkg::REG_FIFO_TIMEOUT, drt_pkg::CFG_DATA_W'(fto));
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// one transfer: begin, then ticks and polls until done, timed out, canceled or 30 steps
	task automatic run_flow();
		request_t r;
		int steps;
		r = random_req(drt_pkg::REQ_BEGIN);
		if (sb.panel_h != '0 && $urandom_range(9) != 0) begin
			r.row_start = drt_pkg::ROW_W'($urandom_range(int'(sb.panel_h) - 1));
			r.row_end = drt_pkg::DIM_W'($urandom_range(int'(sb.panel_h),
				int'(r.row_start) + 1));
			r.image_valid = 1'b1;
			r.dma_busy = 1'b0;
		end
		send_req(r);
		steps = 0;
		while (sb.phase != PH_IDLE && steps < 30) begin
			case ($urandom_range(19))
				0: send_req(random_req(drt_pkg::REQ_CANCEL));
				1, 2, 3, 4, 5, 6: begin
					repeat ($urandom_range(1, 6)) send_req(random_req(drt_pkg::REQ_TICK));
				end
				default: begin
					r = random_req(drt_pkg::REQ_POLL);
					r.dma_busy = ($urandom_range(2) != 0);
					r.fifo_empty = ($urandom_range(3) == 0);
					send_req(r);
				end
			endcase
			steps++;
		end
	endtask

	initial begin
		int target;
		bit paused;
		paused = 1'b0;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.req_type = drt_pkg::REQ_POLL;
		req_bus.row_start = '0;
		req_bus.row_end = '0;
		req_bus.image_valid = 1'b0;
		req_bus.dma_busy = 1'b0;
		req_bus.fifo_empty = 1'b0;
		rsp_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = drt_pkg::REG_PANEL_WIDTH;
		cfg_bus.data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: unconfigured panel first, then the corner cases
		send_req(mk_req(drt_pkg::REQ_BEGIN, 0, 1, 1, 0, 0));
		send_req(mk_req(drt_pkg::REQ_POLL, 0, 0, 0, 0, 0));
		load_panel(drt_pkg::MAX_DIM, drt_pkg::MAX_DIM, 255, 0, 2);
		send_req(mk_req(drt_pkg::REQ_CANCEL, 0, 0, 0, 0, 0));
		send_req(mk_req(drt_pkg::REQ_CANCEL, 0, 0, 0, 1, 0));
		send_req(mk_req(drt_pkg::REQ_BEGIN, 0, 10, 0, 0, 0));
		send_req(mk_req(drt_pkg::REQ_BEGIN, 0, 10, 1, 1, 0));
		send_req(mk_req(drt_pkg::REQ_BEGIN, 7, 7, 1, 0, 0));
		send_req(mk_req(drt_pkg::REQ_BEGIN, 0, 1025, 1, 0, 1));
		send_req(mk_req(drt_pkg::REQ_BEGIN, 1023, 2047, 1, 0, 1));
		send_req(mk_req(drt_pkg::REQ_BEGIN, 1023, 1024, 1, 0, 1));
		send_req(mk_req(drt_pkg::REQ_BEGIN, 0, 4, 1, 0, 0));
		send_req(mk_req(drt_pkg::REQ_POLL, 0, 0, 0, 1, 0));
		send_req(mk_req(drt_pkg::REQ_BEGIN, 0, 1024, 1, 0, 0));
		send_req(mk_req(drt_pkg::REQ_POLL, 0, 0, 1, 0, 0));
		send_req(mk_req(drt_pkg::REQ_TICK, 1023, 2047, 1, 1, 1));
		send_req(mk_req(drt_pkg::REQ_TICK, 0, 0, 0, 0, 0));
		send_req(mk_req(drt_pkg::REQ_POLL, 0, 0, 0, 0, 0));
		send_req(mk_req(drt_pkg::REQ_BEGIN, 512, 700, 1, 0, 0));
		send_req(mk_req(drt_pkg::REQ_POLL, 0, 0, 0, 0, 1));
		send_req(mk_req(drt_pkg::REQ_BEGIN, 3, 4, 1, 0, 0));
		send_req(mk_req(drt_pkg::REQ_CANCEL, 0, 0, 0, 0, 0));
		send_req(mk_req(drt_pkg::REQ_POLL, 0, 0, 0, 1, 1));

		for (int k = 0; k < 9; k++) begin
			snd_idle = (k < 3) ? 34 : (k < 6) ? 61 : 0;
			rcv_idle = (k < 3) ? 61 : (k < 6) ? 34 : 0;
			case (k)
				0: load_panel(drt_pkg::MAX_DIM, drt_pkg::MAX_DIM, 255, 0, 0);
				4: load_panel(1, 1, 0, 20'hfffff, 20'hfffff);
				7: load_panel(0, $urandom_range(1, 64), $urandom_range(255), 3, 3);
				default: begin
					// raw 20-bit dimension writes exercise the masking and saturation
					load_panel(($urandom_range(4) == 0) ? $urandom_range(20'hfffff)
							: $urandom_range(1, 64),
						($urandom_range(4) == 0) ? $urandom_range(20'hfffff)
							: $urandom_range(1, 64),
						$urandom_range(255), $urandom_range(20), $urandom_range(20));
				end
			endcase
			if (k == 2 || k == 6)
				hold_asks++;
			target = n_sent + 50;
			while (n_sent < target) begin
				if (k == 3 && !paused && n_sent >= target - 25) begin
					drain();
					paused = 1'b1;
				end
				if ($urandom_range(3) != 0)
					run_flow();
				else
					send_req(random_req(2'($urandom_range(3))));
			end
			send_req(random_req(drt_pkg::REQ_CANCEL));
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.fail_count == 0 && sb.outstanding() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
